[rtl/mtb_pkg.sv]
// package for the timer bank: sizes, command codes and sequencer states
package mtb_pkg;

  // bank size and counter width
  localparam int TIMER_COUNT = 8;
  localparam int COUNT_WIDTH = 32;

  // fixed field widths
  localparam int CMD_W   = 3;
  localparam int ID_W    = 4;
  localparam int VAL_W   = 32;
  localparam int FIRED_W = 8;

  // slot index width and a width wide enough to compare ids with the bank size
  localparam int IDX_W    = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;
  localparam int ID_CMP_W = 8;

  typedef logic [CMD_W-1:0] cmd_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK   = 3'd0,
    CMD_ALLOC  = 3'd1,
    CMD_SET    = 3'd2,
    CMD_ENABLE = 3'd3,
    CMD_READ   = 3'd4,
    CMD_FREE   = 3'd5
  } cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TICK,
    ST_ALLOC,
    ST_SLOT,
    ST_DONE
  } state_e;

endpackage

[rtl/multi_timer_bank.sv]
// timer bank top level: command decode, slot sequencer and shared decrementer
//
// A bank of TIMER_COUNT countdown timers driven by one command item at a time
// (tick, allocate, set, enable, read, free), each answered by exactly one
// result item. A tick walks the slots one per cycle through a single shared
// decrementer and compare, then presents the result. Allocate walks the same
// slot pointer until it finds the lowest free slot or reaches the last slot.
// Set, enable, read and free act on the named slot. The input is not ready
// while an item is in work or its result waits on the output; the result is
// held in registers until taken.
// Ids outside 1..TIMER_COUNT on slot commands set bad_id and change nothing.
module multi_timer_bank (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [mtb_pkg::CMD_W-1:0]  command_i,
  input  logic [mtb_pkg::ID_W-1:0]   timer_id_i,
  input  logic [mtb_pkg::VAL_W-1:0]  count_value_i,
  input  logic [mtb_pkg::VAL_W-1:0]  reload_value_i,
  input  logic                       repeat_flag_i,
  input  logic                       enable_flag_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [mtb_pkg::ID_W-1:0]   allocated_id_o,
  output logic [mtb_pkg::FIRED_W-1:0] fired_mask_o,
  output logic [mtb_pkg::VAL_W-1:0]  count_out_o,
  output logic [mtb_pkg::VAL_W-1:0]  reload_out_o,
  output logic                       repeat_out_o,
  output logic                       enabled_out_o,
  output logic                       bad_id_o
);
  import mtb_pkg::*;

  localparam int HOT_W = TIMER_COUNT + FIRED_W;

  // sequencer state
  state_e state_q, state_d;
  logic [IDX_W-1:0] idx_q, idx_d;

  // latched command item
  cmd_e                   cmd_q, cmd_d;
  logic [IDX_W-1:0]       slot_q, slot_d;
  logic                   bad_q, bad_d;
  logic [COUNT_WIDTH-1:0] cnt_ld_q, cnt_ld_d;
  logic [COUNT_WIDTH-1:0] rld_ld_q, rld_ld_d;
  logic                   rep_ld_q, rep_ld_d;
  logic                   en_ld_q, en_ld_d;

  // timer state
  logic [COUNT_WIDTH-1:0] cnt_q [TIMER_COUNT];
  logic [COUNT_WIDTH-1:0] cnt_d [TIMER_COUNT];
  logic [COUNT_WIDTH-1:0] rld_q [TIMER_COUNT];
  logic [COUNT_WIDTH-1:0] rld_d [TIMER_COUNT];
  logic [TIMER_COUNT-1:0] rep_q, rep_d;
  logic [TIMER_COUNT-1:0] en_q, en_d;
  logic [TIMER_COUNT-1:0] use_q, use_d;

  // result registers
  logic [ID_W-1:0]    alloc_id_q, alloc_id_d;
  logic [FIRED_W-1:0] fired_q, fired_d;
  logic [VAL_W-1:0]   cnt_out_q, cnt_out_d;
  logic [VAL_W-1:0]   rld_out_q, rld_out_d;
  logic               rep_out_q, rep_out_d;
  logic               en_out_q, en_out_d;
  logic               bad_out_q, bad_out_d;

  // decode and shared unit signals
  logic                   accept;
  logic                   last;
  logic [IDX_W-1:0]       addr;
  logic [COUNT_WIDTH-1:0] cur_cnt;
  logic [COUNT_WIDTH-1:0] dec_cnt;
  logic [ID_CMP_W-1:0]    id_ext;
  logic [ID_CMP_W-1:0]    id_m1;
  logic [HOT_W-1:0]       hot;
  logic [ID_CMP_W-1:0]    idx_p1;
  logic [63:0]            cnt_wide;
  logic [63:0]            rld_wide;

  assign accept = in_valid_i && in_ready_o;
  assign last   = (idx_q == IDX_W'(TIMER_COUNT - 1));
  assign id_ext = ID_CMP_W'(timer_id_i);
  assign id_m1  = id_ext - ID_CMP_W'(1);

  // one memory port: the named slot in ST_SLOT, the slot pointer otherwise
  assign addr    = (state_q == ST_SLOT) ? slot_q : idx_q;
  assign cur_cnt = cnt_q[addr];
  assign dec_cnt = cur_cnt - COUNT_WIDTH'(1);
  assign hot     = HOT_W'(1) << idx_q;
  assign idx_p1  = ID_CMP_W'(idx_q) + ID_CMP_W'(1);
  assign cnt_wide = 64'(cur_cnt);
  assign rld_wide = 64'(rld_q[addr]);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (cmd_e'(command_i))
            CMD_TICK:  state_d = ST_TICK;
            CMD_ALLOC: state_d = ST_ALLOC;
            default:   state_d = ST_SLOT;
          endcase
        end
      end
      ST_TICK: begin
        if (last) state_d = ST_DONE;
      end
      ST_ALLOC: begin
        if (!use_q[idx_q] || last) state_d = ST_DONE;
      end
      ST_SLOT: state_d = ST_DONE;
      ST_DONE: begin
        if (out_ready_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    in_ready_o  = (state_q == ST_IDLE);
    out_valid_o = (state_q == ST_DONE);
  end

  // datapath: latch item, walk slots, execute slot commands
  always_comb begin
    idx_d      = idx_q;
    cmd_d      = cmd_q;
    slot_d     = slot_q;
    bad_d      = bad_q;
    cnt_ld_d   = cnt_ld_q;
    rld_ld_d   = rld_ld_q;
    rep_ld_d   = rep_ld_q;
    en_ld_d    = en_ld_q;
    cnt_d      = cnt_q;
    rld_d      = rld_q;
    rep_d      = rep_q;
    en_d       = en_q;
    use_d      = use_q;
    alloc_id_d = alloc_id_q;
    fired_d    = fired_q;
    cnt_out_d  = cnt_out_q;
    rld_out_d  = rld_out_q;
    rep_out_d  = rep_out_q;
    en_out_d   = en_out_q;
    bad_out_d  = bad_out_q;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          idx_d      = '0;
          cmd_d      = cmd_e'(command_i);
          slot_d     = id_m1[IDX_W-1:0];
          bad_d      = (id_ext == '0) || (id_ext > ID_CMP_W'(TIMER_COUNT));
          cnt_ld_d   = COUNT_WIDTH'(count_value_i);
          rld_ld_d   = COUNT_WIDTH'(reload_value_i);
          rep_ld_d   = repeat_flag_i;
          en_ld_d    = enable_flag_i;
          alloc_id_d = '0;
          fired_d    = '0;
          cnt_out_d  = '0;
          rld_out_d  = '0;
          rep_out_d  = 1'b0;
          en_out_d   = 1'b0;
          bad_out_d  = 1'b0;
        end
      end

      // one slot through the shared decrementer per cycle
      ST_TICK: begin
        if (en_q[addr]) begin
          if (dec_cnt == '0) begin
            fired_d = fired_q | hot[FIRED_W-1:0];
            if (rep_q[addr]) begin
              cnt_d[addr] = rld_q[addr];
            end else begin
              cnt_d[addr] = dec_cnt;
              en_d[addr]  = 1'b0;
            end
          end else begin
            cnt_d[addr] = dec_cnt;
          end
        end
        if (!last) idx_d = idx_q + IDX_W'(1);
      end

      // lowest free slot search
      ST_ALLOC: begin
        if (!use_q[addr]) begin
          cnt_d[addr] = cnt_ld_q;
          rld_d[addr] = rld_ld_q;
          rep_d[addr] = rep_ld_q;
          en_d[addr]  = 1'b1;
          use_d[addr] = 1'b1;
          alloc_id_d  = idx_p1[ID_W-1:0];
        end else if (!last) begin
          idx_d = idx_q + IDX_W'(1);
        end
      end

      ST_SLOT: begin
        case (cmd_q)
          CMD_SET: begin
            if (bad_q) begin
              bad_out_d = 1'b1;
            end else begin
              cnt_d[addr] = cnt_ld_q;
              rld_d[addr] = rld_ld_q;
              rep_d[addr] = rep_ld_q;
            end
          end
          CMD_ENABLE: begin
            if (bad_q) begin
              bad_out_d = 1'b1;
            end else begin
              en_d[addr] = en_ld_q;
            end
          end
          CMD_READ: begin
            if (bad_q) begin
              bad_out_d = 1'b1;
            end else begin
              cnt_out_d = cnt_wide[VAL_W-1:0];
              rld_out_d = rld_wide[VAL_W-1:0];
              rep_out_d = rep_q[addr];
              en_out_d  = en_q[addr];
            end
          end
          CMD_FREE: begin
            if (bad_q) begin
              bad_out_d = 1'b1;
            end else begin
              cnt_d[addr] = '0;
              rld_d[addr] = '0;
              rep_d[addr] = 1'b0;
              en_d[addr]  = 1'b0;
              use_d[addr] = 1'b0;
            end
          end
          default: ;
        endcase
      end

      default: ;
    endcase
  end

  // control and timer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
      rep_q   <= '0;
      en_q    <= '0;
      use_q   <= '0;
      for (int i = 0; i < TIMER_COUNT; i++) begin
        cnt_q[i] <= '0;
        rld_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      rep_q   <= rep_d;
      en_q    <= en_d;
      use_q   <= use_d;
      cnt_q   <= cnt_d;
      rld_q   <= rld_d;
    end
  end

  // item and result payload
  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    slot_q     <= slot_d;
    bad_q      <= bad_d;
    cnt_ld_q   <= cnt_ld_d;
    rld_ld_q   <= rld_ld_d;
    rep_ld_q   <= rep_ld_d;
    en_ld_q    <= en_ld_d;
    alloc_id_q <= alloc_id_d;
    fired_q    <= fired_d;
    cnt_out_q  <= cnt_out_d;
    rld_out_q  <= rld_out_d;
    rep_out_q  <= rep_out_d;
    en_out_q   <= en_out_d;
    bad_out_q  <= bad_out_d;
  end

  assign allocated_id_o = alloc_id_q;
  assign fired_mask_o   = fired_q;
  assign count_out_o    = cnt_out_q;
  assign reload_out_o   = rld_out_q;
  assign repeat_out_o   = rep_out_q;
  assign enabled_out_o  = en_out_q;
  assign bad_id_o       = bad_out_q;

  // checks
  a_fired_only_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (cmd_q != CMD_TICK) |-> fired_mask_o == '0)
    else $error("fired mask set on a non-tick result");

  a_alloc_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ID_CMP_W'(allocated_id_o) <= ID_CMP_W'(TIMER_COUNT))
    else $error("allocated id beyond bank");

  a_bad_clears_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && bad_id_o |-> (count_out_o == '0) && (reload_out_o == '0)
                                && !repeat_out_o && !enabled_out_o)
    else $error("read fields set with bad id");

  a_alloc_marks_use: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ALLOC) && !use_q[idx_q] |=> use_q[$past(idx_q)] && en_q[$past(idx_q)])
    else $error("allocated slot not marked in use");

  a_back_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i |=> in_ready_o && !out_valid_o)
    else $error("no return to idle after result taken");

endmodule
